// ===== hdl/bit_banged_adc_poll_sequencer_unit_macros.svh =====
// Assertion macros shared by the poll sequencer RTL.
`ifndef BIT_BANGED_ADC_POLL_SEQUENCER_UNIT_MACROS_SVH
`define BIT_BANGED_ADC_POLL_SEQUENCER_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BBAPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define BBAPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bbaps_pkg.sv =====
// Package with frame constants and shared types for the ADC poll sequencer.
package bbaps_pkg;

  typedef logic [5:0] step_t;

  // Frame schedule
  localparam step_t FRAME_LAST         = 6'd41;
  localparam step_t CS_RISE_STEP       = 6'd35;
  localparam step_t DATA_LAST_STEP     = 6'd16;
  localparam step_t CAPTURE_CLEAR_STEP = 6'd4;
  localparam step_t CAPTURE_FIRST      = 6'd12;
  localparam step_t CAPTURE_SHIFT_LAST = 6'd24;
  localparam step_t CAPTURE_FINAL      = 6'd26;

  // Command words for the two channels
  localparam logic [7:0] CMD_FORWARD   = 8'h08;
  localparam logic [7:0] CMD_REFLECTED = 8'h00;

  // Status byte bit positions
  localparam int unsigned ADC_BIT_POS  = 6;
  localparam int unsigned PTT_BIT_POS  = 7;
  localparam int unsigned DASH_BIT_POS = 4;
  localparam int unsigned DOT_BIT_POS  = 5;

  // Result of one frame step, from the frame sequencer to the top level
  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi;
    logic [7:0] forward_level;
    logic [7:0] reflected_level;
    logic       forward_event;
  } frame_res_t;

endpackage

// ===== hdl/bbaps_in_if.sv =====
// Input channel: one status byte per poll tick.
interface bbaps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;

  modport source (output valid, output status_byte, input ready);
  modport sink   (input valid, input status_byte, output ready);
endinterface

// ===== hdl/bbaps_out_if.sv =====
// Output channel: pin levels, power readings and key state per tick.
interface bbaps_out_if;
  logic       valid;
  logic       ready;
  logic       adc_cs_n;
  logic       adc_sclk;
  logic       adc_mosi;
  logic [7:0] forward_level;
  logic [7:0] reflected_level;
  logic       forward_event;
  logic       ptt_level;
  logic       dash_level;
  logic       dot_level;
  logic [2:0] key_changes;

  modport source (
    output valid, output adc_cs_n, output adc_sclk, output adc_mosi,
    output forward_level, output reflected_level, output forward_event,
    output ptt_level, output dash_level, output dot_level, output key_changes,
    input ready
  );
  modport sink (
    input valid, input adc_cs_n, input adc_sclk, input adc_mosi,
    input forward_level, input reflected_level, input forward_event,
    input ptt_level, input dash_level, input dot_level, input key_changes,
    output ready
  );
endinterface

// ===== hdl/bit_banged_adc_poll_sequencer_unit.sv =====
// Top level of the bit-banged serial ADC poll sequencer.
//
//  channel  direction  payload                                   accepted when
//  status   in         status_byte[7:0]                          valid && ready
//  result   out        pins, forward/reflected level, event,     valid && ready
//                      ptt/dash/dot levels, key_changes[2:0]
//
// One tick per clock: a status item is taken in any cycle in which the result
// register is empty or being drained, and its result appears in that register
// the next cycle. rst (synchronous) restarts the frame on the reflected
// channel and empties the result register. A stalled result holds the input
// side only while the register is full and not taken.
`include "bit_banged_adc_poll_sequencer_unit_macros.svh"

module bit_banged_adc_poll_sequencer_unit (
  input  logic               clk,
  input  logic               rst,
  bbaps_in_if.sink           status,
  bbaps_out_if.source        result
);

  logic                  accept;
  logic [2:0]            keys;
  logic [2:0]            key_levels;
  logic                  out_valid;
  bbaps_pkg::frame_res_t frame_res;

  assign status.ready = !out_valid || result.ready;
  assign accept       = status.valid && status.ready;

  // Key levels from the status byte: bit0 ptt, bit1 dash, bit2 dot
  assign keys = {status.status_byte[bbaps_pkg::DOT_BIT_POS],
                 status.status_byte[bbaps_pkg::DASH_BIT_POS],
                 status.status_byte[bbaps_pkg::PTT_BIT_POS]};

  bbaps_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .adc_bit (status.status_byte[bbaps_pkg::ADC_BIT_POS]),
    .res     (frame_res)
  );

  // Previous key levels for change detection
  always_ff @(posedge clk) begin
    if (rst) begin
      key_levels <= 3'b000;
    end else if (accept) begin
      key_levels <= keys;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result.adc_cs_n        <= frame_res.cs_n;
      result.adc_sclk        <= frame_res.sclk;
      result.adc_mosi        <= frame_res.mosi;
      result.forward_level   <= frame_res.forward_level;
      result.reflected_level <= frame_res.reflected_level;
      result.forward_event   <= frame_res.forward_event;
      result.ptt_level       <= keys[0];
      result.dash_level      <= keys[1];
      result.dot_level       <= keys[2];
      result.key_changes     <= keys ^ key_levels;
    end
  end

  assign result.valid = out_valid;

  `BBAPS_ASSERT_NEXT(a_accept_fills, accept, result.valid, "accepted item gave no result")
  `BBAPS_ASSERT(a_empty_ready, !result.valid |-> status.ready, "input blocked with empty result register")
  `BBAPS_ASSERT_NEXT(a_ptt_follows, accept, result.ptt_level == $past(status.status_byte[bbaps_pkg::PTT_BIT_POS]), "ptt level does not follow status bit")

endmodule

// ===== hdl/bbaps_frame.sv =====
// Frame sequencer: step counter, pin pattern, bit capture and stored readings.
`include "bit_banged_adc_poll_sequencer_unit_macros.svh"

module bbaps_frame (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   adc_bit,
  output bbaps_pkg::frame_res_t  res
);

  bbaps_pkg::step_t step, step_next;
  logic             channel_is_forward, channel_is_forward_next;
  logic [7:0]       command_word, command_word_next;
  logic [7:0]       capture_shift, capture_shift_next;
  logic [7:0]       forward_value, forward_value_next;
  logic [7:0]       reflected_value, reflected_value_next;
  logic             cs_n, cs_n_next;
  logic             sclk, sclk_next;
  logic             mosi, mosi_next;
  logic             event_next;
  bbaps_pkg::step_t step_m1;
  logic [2:0]       bit_idx;
  logic             frame_end;

  // Next state for one tick
  always_comb begin
    step_m1   = step - 6'd1;
    bit_idx   = step_m1[3:1];
    frame_end = (step >= bbaps_pkg::FRAME_LAST);

    // command word is chosen at the start of the frame and used right away
    if (step == 6'd0) begin
      command_word_next = channel_is_forward ? bbaps_pkg::CMD_FORWARD
                                             : bbaps_pkg::CMD_REFLECTED;
    end else begin
      command_word_next = command_word;
    end

    // pin pattern; idle steps after cs rise hold the pins
    if (step > bbaps_pkg::CS_RISE_STEP) begin
      cs_n_next = cs_n;
      sclk_next = sclk;
      mosi_next = mosi;
    end else begin
      cs_n_next = (step == bbaps_pkg::CS_RISE_STEP);
      sclk_next = (step == bbaps_pkg::CS_RISE_STEP) || !step[0];
      if (step == 6'd0) begin
        mosi_next = command_word_next[7];
      end else if (step <= bbaps_pkg::DATA_LAST_STEP) begin
        mosi_next = command_word_next[~bit_idx];
      end else begin
        mosi_next = 1'b0;
      end
    end

    // capture of the conversion result, MSB first
    if (step == bbaps_pkg::CAPTURE_CLEAR_STEP) begin
      capture_shift_next = 8'h00;
    end else if (step inside {[bbaps_pkg::CAPTURE_FIRST:bbaps_pkg::CAPTURE_SHIFT_LAST]}
                 && !step[0]) begin
      capture_shift_next = {capture_shift[6:0] | {6'd0, adc_bit}, 1'b0};
    end else if (step == bbaps_pkg::CAPTURE_FINAL) begin
      capture_shift_next = capture_shift | {7'd0, adc_bit};
    end else begin
      capture_shift_next = capture_shift;
    end

    // end of frame: store the reading and swap channels
    forward_value_next      = forward_value;
    reflected_value_next    = reflected_value;
    channel_is_forward_next = channel_is_forward;
    event_next              = 1'b0;
    if (frame_end) begin
      if (channel_is_forward) begin
        forward_value_next = capture_shift;
        event_next         = 1'b1;
      end else begin
        reflected_value_next = capture_shift;
      end
      channel_is_forward_next = !channel_is_forward;
      step_next               = 6'd0;
    end else begin
      step_next = step + 6'd1;
    end

    res.cs_n            = cs_n_next;
    res.sclk            = sclk_next;
    res.mosi            = mosi_next;
    res.forward_level   = forward_value_next;
    res.reflected_level = reflected_value_next;
    res.forward_event   = event_next;
  end

  // State registers, updated once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      step               <= 6'd0;
      channel_is_forward <= 1'b0;
      command_word       <= 8'h00;
      capture_shift      <= 8'h00;
      forward_value      <= 8'h00;
      reflected_value    <= 8'h00;
      cs_n               <= 1'b0;
      sclk               <= 1'b1;
      mosi               <= 1'b0;
    end else if (advance) begin
      step               <= step_next;
      channel_is_forward <= channel_is_forward_next;
      command_word       <= command_word_next;
      capture_shift      <= capture_shift_next;
      forward_value      <= forward_value_next;
      reflected_value    <= reflected_value_next;
      cs_n               <= cs_n_next;
      sclk               <= sclk_next;
      mosi               <= mosi_next;
    end
  end

  `BBAPS_ASSERT(a_step_in_frame, step <= bbaps_pkg::FRAME_LAST, "frame step past end of frame")
  `BBAPS_ASSERT(a_event_only_forward, res.forward_event |-> (frame_end && channel_is_forward), "forward event outside a forward frame end")
  `BBAPS_ASSERT_NEXT(a_swap_at_end, advance && frame_end, step == 6'd0 && channel_is_forward != $past(channel_is_forward), "channel not swapped at frame end")

endmodule

// ===== tb/tb_bit_banged_adc_poll_sequencer_unit.sv =====
// Testbench for the bit-banged ADC poll sequencer: directed and random status ticks, checked item by item.
module tb_bit_banged_adc_poll_sequencer_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 100000;
  localparam int FRAME_TICKS    = 42;
  localparam int RANDOM_FRAMES  = 25;
  localparam int LONG_HOLD      = 250;
  localparam int HOLD_AFTER     = 800;
  localparam int DRAIN_CYCLES   = 5;

  // One result item as the block should present it
  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi;
    logic [7:0] fwd_level;
    logic [7:0] refl_level;
    logic       fwd_event;
    logic       ptt;
    logic       dash;
    logic       dot;
    logic [2:0] changes;
  } poll_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbaps_in_if  status_if ();
  bbaps_out_if result_if ();

  bit_banged_adc_poll_sequencer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .status (status_if),
    .result (result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectations
  logic [7:0]   pending_bytes[$];
  poll_result_t poll_results_due[$];
  int           total_items;
  int           items_taken;
  int           sender_idle_pct    = 24;
  int           receiver_stall_pct = 59;
  int           error_count        = 0;
  int           results_seen       = 0;
  int           fwd_events_seen    = 0;
  int           cycle_count        = 0;
  int           hold_left;
  bit           hold_done;

  // Sequencer state as tracked by the testbench
  bbaps_pkg::step_t frame_pos;
  logic             on_forward;
  logic [7:0]       cmd_word;
  logic [7:0]       capture_reg;
  logic [7:0]       fwd_val;
  logic [7:0]       refl_val;
  logic             pin_cs_n;
  logic             pin_sclk;
  logic             pin_mosi;
  logic [2:0]       keys_prev;

  // Advance the tracked sequencer by one poll tick and return its result
  function automatic poll_result_t predict_poll_tick(logic [7:0] st);
    poll_result_t     r;
    bbaps_pkg::step_t s;
    logic             adc_bit;
    logic [2:0]       keys;
    logic [2:0]       bit_idx;
    s       = frame_pos;
    adc_bit = st[bbaps_pkg::ADC_BIT_POS];
    r       = '0;

    if (s == 6'd0) begin
      cmd_word = on_forward ? bbaps_pkg::CMD_FORWARD : bbaps_pkg::CMD_REFLECTED;
    end

    // Pin pattern; idle steps at the tail keep the old levels
    if (s <= bbaps_pkg::CS_RISE_STEP) begin
      pin_cs_n = 1'b0;
      pin_sclk = ~s[0];
      if (s == bbaps_pkg::CS_RISE_STEP) begin
        pin_cs_n = 1'b1;
        pin_sclk = 1'b1;
      end
      if (s == 6'd0) begin
        pin_mosi = cmd_word[7];
      end else if (s <= bbaps_pkg::DATA_LAST_STEP) begin
        bit_idx  = 3'd7 - 3'((s - 6'd1) >> 1);
        pin_mosi = cmd_word[bit_idx];
      end else begin
        pin_mosi = 1'b0;
      end
    end

    // Data capture from status bit 6
    if (s == bbaps_pkg::CAPTURE_CLEAR_STEP) begin
      capture_reg = '0;
    end else if (s >= bbaps_pkg::CAPTURE_FIRST && s <= bbaps_pkg::CAPTURE_SHIFT_LAST
                 && !s[0]) begin
      capture_reg = (capture_reg | {7'd0, adc_bit}) << 1;
    end else if (s == bbaps_pkg::CAPTURE_FINAL) begin
      capture_reg = capture_reg | {7'd0, adc_bit};
    end

    // End of frame: store, flag forward readings, swap channel
    if (s >= bbaps_pkg::FRAME_LAST) begin
      if (on_forward) begin
        fwd_val     = capture_reg;
        r.fwd_event = 1'b1;
      end else begin
        refl_val = capture_reg;
      end
      on_forward = ~on_forward;
      frame_pos  = '0;
    end else begin
      frame_pos = s + 6'd1;
    end

    keys      = {st[bbaps_pkg::DOT_BIT_POS], st[bbaps_pkg::DASH_BIT_POS],
                 st[bbaps_pkg::PTT_BIT_POS]};
    r.changes = keys ^ keys_prev;
    keys_prev = keys;

    r.cs_n       = pin_cs_n;
    r.sclk       = pin_sclk;
    r.mosi       = pin_mosi;
    r.fwd_level  = fwd_val;
    r.refl_level = refl_val;
    r.ptt        = keys[0];
    r.dash       = keys[1];
    r.dot        = keys[2];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d field %s got 0x%0h want 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // Driver: offers queued status bytes, records expectations on acceptance
  always @(posedge clk) begin
    if (rst) begin
      status_if.valid       <= 1'b0;
      status_if.status_byte <= '0;
      items_taken           <= 0;
      frame_pos   = '0;
      on_forward  = 1'b0;
      cmd_word    = '0;
      capture_reg = '0;
      fwd_val     = '0;
      refl_val    = '0;
      pin_cs_n    = 1'b0;
      pin_sclk    = 1'b1;
      pin_mosi    = 1'b0;
      keys_prev   = '0;
    end else begin
      if (status_if.valid && status_if.ready) begin
        poll_results_due.push_back(predict_poll_tick(status_if.status_byte));
        items_taken <= items_taken + 1;
      end
      if (status_if.valid && !status_if.ready) begin
        // stalled: hold the current item
      end else if (pending_bytes.size() != 0 &&
                   $urandom_range(0, 99) >= sender_idle_pct) begin
        status_if.valid       <= 1'b1;
        status_if.status_byte <= pending_bytes.pop_front();
      end else begin
        status_if.valid       <= 1'b0;
        status_if.status_byte <= 8'($urandom);
      end
    end
  end

  // Receiver ready, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else if (!hold_done && items_taken >= HOLD_AFTER) begin
      hold_done       <= 1'b1;
      hold_left       <= LONG_HOLD;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    poll_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (poll_results_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = poll_results_due.pop_front();
        check_field("adc_cs_n", result_if.adc_cs_n, want.cs_n);
        check_field("adc_sclk", result_if.adc_sclk, want.sclk);
        check_field("adc_mosi", result_if.adc_mosi, want.mosi);
        check_field("forward_level", result_if.forward_level, want.fwd_level);
        check_field("reflected_level", result_if.reflected_level, want.refl_level);
        check_field("forward_event", result_if.forward_event, want.fwd_event);
        check_field("ptt_level", result_if.ptt_level, want.ptt);
        check_field("dash_level", result_if.dash_level, want.dash);
        check_field("dot_level", result_if.dot_level, want.dot);
        check_field("key_changes", result_if.key_changes, want.changes);
        if (want.fwd_event) begin
          fwd_events_seen++;
        end
      end
      results_seen++;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [7:0] directed[$];
    logic [2:0] keys_hold;
    logic       adc_bit;
    int         mode;

    // Directed: extremes, each key and the ADC bit alone, key toggles
    directed = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h10, 8'h00, 8'h20,
                 8'h00, 8'h40, 8'h40, 8'hB0, 8'hB0, 8'h30, 8'h90, 8'hA0,
                 8'h0F, 8'hF0, 8'h4F, 8'hBF, 8'h55, 8'hAA, 8'hFF, 8'h7F,
                 8'h00};
    foreach (directed[i]) begin
      pending_bytes.push_back(directed[i]);
    end
    // Fill out the first frame so later frames line up with the capture window
    for (int i = directed.size(); i < FRAME_TICKS; i++) begin
      pending_bytes.push_back(8'($urandom));
    end

    // Random frames: ADC data random or stuck high/low, keys held with rare changes
    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      mode      = $urandom_range(0, 3);
      keys_hold = 3'($urandom);
      for (int i = 0; i < FRAME_TICKS; i++) begin
        case (mode)
          1: adc_bit = 1'b1;
          2: adc_bit = 1'b0;
          default: adc_bit = 1'($urandom);
        endcase
        if ($urandom_range(0, 7) == 0) begin
          keys_hold = 3'($urandom);
        end
        pending_bytes.push_back({keys_hold[0], adc_bit, keys_hold[2], keys_hold[1],
                                 4'($urandom)});
      end
    end
    total_items = pending_bytes.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Idle phases: sender light / receiver heavy, then swapped, then none
    while (items_taken < total_items / 3) @(posedge clk);
    sender_idle_pct    = 59;
    receiver_stall_pct = 24;
    while (items_taken < (2 * total_items) / 3) @(posedge clk);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;

    while (items_taken < total_items) @(posedge clk);
    while (poll_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (poll_results_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", poll_results_due.size()));
    end

    $display("Ran %0d status ticks (%0d frames), checked %0d results, %0d forward events.",
             total_items, total_items / FRAME_TICKS, results_seen, fwd_events_seen);
    $display("Covered both idle mixes, a %0d-cycle output hold-off and %0d mismatches.",
             LONG_HOLD, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bbaps_pkg.sv
hdl/bbaps_in_if.sv
hdl/bbaps_out_if.sv
hdl/bbaps_frame.sv
hdl/bit_banged_adc_poll_sequencer_unit.sv
tb/tb_bit_banged_adc_poll_sequencer_unit.sv
